// ===== rtl/lfrr_pkg.sv =====
`default_nettype none

package lfrr_pkg;

    // List and core space.
    localparam int LIST_DEPTH = 16;
    localparam int CORE_COUNT = 64;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int CORE_W    = 6;
    localparam int TIME_W    = 31;
    localparam int MASK_W    = 64;
    localparam int PCT_W     = 7;
    localparam int IRQ_LIM_W = 32;
    localparam int MAXC_W    = 5;

    // Arithmetic widths: total of seven counters plus one, and total times 100.
    localparam int TOTAL_W       = 34;
    localparam int PAIR_W        = 32;
    localparam int NUM_W         = 41;
    localparam int PERCENT_SCALE = 100;
    localparam int STEP_W        = 3;
    localparam int SUM_STEPS     = 5;
    localparam int DIV_STEPS     = 7;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_BUSY_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IRQ_LIMIT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CORES  = 2'd2;

    // Input tdata layout, lowest bit first.
    localparam int OFF_CORE_ID = 0;
    localparam int OFF_USER    = OFF_CORE_ID + CORE_W;
    localparam int OFF_NICE    = OFF_USER + TIME_W;
    localparam int OFF_SYSTEM  = OFF_NICE + TIME_W;
    localparam int OFF_IDLE    = OFF_SYSTEM + TIME_W;
    localparam int OFF_IOWAIT  = OFF_IDLE + TIME_W;
    localparam int OFF_IRQ     = OFF_IOWAIT + TIME_W;
    localparam int OFF_SOFTIRQ = OFF_IRQ + TIME_W;
    localparam int OFF_LAST    = OFF_SOFTIRQ + TIME_W;
    localparam int OFF_REQ     = OFF_LAST + CORE_W;
    localparam int OFF_MASK    = OFF_REQ + CORE_W;
    localparam int S_TDATA_W   = 304;
    localparam int M_TDATA_W   = 24;
    localparam int M_USED_W    = 1 + CORE_W + 1 + PCT_W + CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_PICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_BUSY,
        ST_MUL,
        ST_DIV,
        ST_FIND,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic sum_step;
        logic busy_step;
        logic mul_step;
        logic div_step;
        logic find_step;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t in_cmd;
        logic in_valid;
        logic list_empty;
        logic sum_last;
        logic div_last;
        logic find_done;
        logic scan_end;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/load_filtered_round_robin_picker.sv =====
// Load-filtered round-robin core picker.
// One transaction on the slave stream carries a command in s_tuser (clear,
// add, pick, no operation) and the core id, seven load counters, last core,
// requesting core and queue-full mask in s_tdata. Each transaction gives
// exactly one result transaction on the master stream.
// Clear and no operation go straight from acceptance to the result.
// An add runs through the accepting cycle, five accumulation steps for the
// total, one subtract, one multiply by 100, a 7-step restoring divide for the
// busy percent and the registering of the result.
// A pick walks the list one entry a cycle: up to list_count entries to find
// the last core, then up to min(max_cores, 16) entries to scan. The result
// shows in the same cycle that s_tready rises again. One transaction is
// worked on at a time.
// Reset empties the list and loads the register defaults (limit 80 percent,
// interrupt limit 1000000, four cores). When the receiver stalls, the result
// stays in the output register and the next transaction is taken; its result
// waits until the held one is taken.
// Configuration writes through cfg_wr_en, cfg_addr and cfg_wr_data take effect
// at once and belong only to idle periods.
`default_nettype none

module load_filtered_round_robin_picker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lfrr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lfrr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // core_id, user_time, nice_time, system_time, idle_time, iowait_time,
    // irq_time, softirq_time, last_core, requesting_core, queue_full_mask
    input  wire logic [lfrr_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic [lfrr_pkg::CMD_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found, chosen_core, core_busy, busy_percent, list_count
    output logic      [lfrr_pkg::M_TDATA_W-1:0]  m_tdata
);

    lfrr_pkg::ctrl_cmd_t  cmd;
    lfrr_pkg::dp_status_t status;

    // Sequencer.
    lfrr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Arithmetic, list and output register.
    lfrr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

    assign s_tready = cmd.accept;

endmodule

`default_nettype wire

// ===== rtl/lfrr_ctrl.sv =====
`default_nettype none

module lfrr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfrr_pkg::dp_status_t status,
    output lfrr_pkg::ctrl_cmd_t      cmd
);

    lfrr_pkg::state_t state_reg;
    lfrr_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfrr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfrr_pkg::ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    unique case (status.in_cmd)
                        lfrr_pkg::CMD_ADD:
                        begin
                            state_next = lfrr_pkg::ST_SUM;
                        end
                        lfrr_pkg::CMD_PICK:
                        begin
                            state_next = status.list_empty ? lfrr_pkg::ST_DONE
                                                           : lfrr_pkg::ST_FIND;
                        end
                        default:
                        begin
                            state_next = lfrr_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lfrr_pkg::ST_SUM:
            begin
                if (status.sum_last)
                begin
                    state_next = lfrr_pkg::ST_BUSY;
                end
            end
            lfrr_pkg::ST_BUSY:
            begin
                state_next = lfrr_pkg::ST_MUL;
            end
            lfrr_pkg::ST_MUL:
            begin
                state_next = lfrr_pkg::ST_DIV;
            end
            lfrr_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = lfrr_pkg::ST_DONE;
                end
            end
            lfrr_pkg::ST_FIND:
            begin
                if (status.find_done)
                begin
                    state_next = lfrr_pkg::ST_SCAN;
                end
            end
            lfrr_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = lfrr_pkg::ST_DONE;
                end
            end
            lfrr_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = lfrr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfrr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            lfrr_pkg::ST_IDLE:
            begin
                cmd.accept = 1'b1;
                cmd.load   = status.in_valid;
            end
            lfrr_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
            end
            lfrr_pkg::ST_BUSY:
            begin
                cmd.busy_step = 1'b1;
            end
            lfrr_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            lfrr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            lfrr_pkg::ST_FIND:
            begin
                cmd.find_step = 1'b1;
            end
            lfrr_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            lfrr_pkg::ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lfrr_dpath.sv =====
`default_nettype none

module lfrr_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lfrr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [lfrr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                                s_tvalid,
    input  wire logic [lfrr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [lfrr_pkg::CMD_W-1:0]          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [lfrr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire lfrr_pkg::ctrl_cmd_t                 cmd,
    output lfrr_pkg::dp_status_t                     status
);

    // Configuration registers.
    logic [lfrr_pkg::PCT_W-1:0]     busy_limit_reg;
    logic [lfrr_pkg::IRQ_LIM_W-1:0] irq_limit_reg;
    logic [lfrr_pkg::MAXC_W-1:0]    max_cores_reg;

    // Captured transaction.
    lfrr_pkg::cmd_t              cmd_reg;
    logic [lfrr_pkg::CORE_W-1:0] id_reg;
    logic [lfrr_pkg::TIME_W-1:0] system_reg;
    logic [lfrr_pkg::TIME_W-1:0] idle_reg;
    logic [lfrr_pkg::TIME_W-1:0] iowait_reg;
    logic [lfrr_pkg::TIME_W-1:0] irq_reg;
    logic [lfrr_pkg::TIME_W-1:0] softirq_reg;
    logic [lfrr_pkg::CORE_W-1:0] last_reg;
    logic [lfrr_pkg::CORE_W-1:0] req_reg;
    logic [lfrr_pkg::MASK_W-1:0] mask_reg;

    // Load arithmetic.
    logic [lfrr_pkg::TOTAL_W-1:0] acc_reg;
    logic [lfrr_pkg::PAIR_W-1:0]  idle_io_reg;
    logic [lfrr_pkg::PAIR_W-1:0]  irq_sum_reg;
    logic                         irq_over_reg;
    logic [lfrr_pkg::NUM_W-1:0]   num_reg;
    logic [lfrr_pkg::PCT_W-1:0]   quot_reg;
    logic [lfrr_pkg::STEP_W-1:0]  step_reg;

    // Core list and walk.
    logic [lfrr_pkg::CORE_W-1:0] list_reg [lfrr_pkg::LIST_DEPTH];
    logic [lfrr_pkg::CNT_W-1:0]  count_reg;
    logic [lfrr_pkg::CNT_W-1:0]  count_next;
    logic [lfrr_pkg::IDX_W-1:0]  idx_reg;
    logic [lfrr_pkg::CNT_W-1:0]  scan_cnt_reg;
    logic                        found_reg;
    logic [lfrr_pkg::CORE_W-1:0] chosen_reg;

    // Output register.
    logic                            out_valid_reg;
    logic [lfrr_pkg::M_TDATA_W-1:0]  out_data_reg;

    logic [lfrr_pkg::TIME_W-1:0]  term;
    logic [lfrr_pkg::NUM_W-1:0]   div_shifted;
    logic                         div_ge;
    logic [lfrr_pkg::CNT_W-1:0]   eff_limit;
    logic [lfrr_pkg::CORE_W-1:0]  entry;
    logic [lfrr_pkg::CNT_W-1:0]   idx_plus;
    logic [lfrr_pkg::IDX_W-1:0]   idx_wrap;
    logic                         find_match;
    logic                         in_range;
    logic                         hit;
    logic                         is_add;
    logic                         busy_flag;
    logic                         id_ok;
    logic                         append;
    logic [lfrr_pkg::M_USED_W-1:0] out_fields;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_limit_reg <= lfrr_pkg::PCT_W'(80);
            irq_limit_reg  <= lfrr_pkg::IRQ_LIM_W'(1000000);
            max_cores_reg  <= lfrr_pkg::MAXC_W'(4);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                lfrr_pkg::REG_BUSY_LIMIT:
                begin
                    busy_limit_reg <= cfg_wr_data[lfrr_pkg::PCT_W-1:0];
                end
                lfrr_pkg::REG_IRQ_LIMIT:
                begin
                    irq_limit_reg <= cfg_wr_data[lfrr_pkg::IRQ_LIM_W-1:0];
                end
                lfrr_pkg::REG_MAX_CORES:
                begin
                    max_cores_reg <= cfg_wr_data[lfrr_pkg::MAXC_W-1:0];
                end
                default:
                begin
                    busy_limit_reg <= busy_limit_reg;
                end
            endcase
        end
    end

    // Summation operand for each step; the carry of one is added on the first.
    always_comb
    begin
        unique case (step_reg)
            3'd0:    term = system_reg;
            3'd1:    term = idle_reg;
            3'd2:    term = iowait_reg;
            3'd3:    term = irq_reg;
            default: term = softirq_reg;
        endcase
    end

    // One restoring division step: compare against the total shifted into place.
    assign div_shifted = lfrr_pkg::NUM_W'(acc_reg) << step_reg;
    assign div_ge      = (num_reg >= div_shifted);

    // The list limit is the configured maximum, capped at the list depth.
    always_comb
    begin
        if (int'(max_cores_reg) > lfrr_pkg::LIST_DEPTH)
        begin
            eff_limit = lfrr_pkg::CNT_W'(lfrr_pkg::LIST_DEPTH);
        end
        else
        begin
            eff_limit = lfrr_pkg::CNT_W'(max_cores_reg);
        end
    end

    // List walk: one entry a cycle, the index wraps at the fill count.
    assign entry      = list_reg[idx_reg];
    assign idx_plus   = lfrr_pkg::CNT_W'(idx_reg) + lfrr_pkg::CNT_W'(1);
    assign idx_wrap   = (idx_plus == count_reg) ? '0 : idx_plus[lfrr_pkg::IDX_W-1:0];
    assign find_match = (entry == last_reg);
    assign in_range   = (scan_cnt_reg < eff_limit);
    assign hit        = in_range && (entry != req_reg) && !mask_reg[entry];

    // Result of an add and the list update.
    assign is_add    = (cmd_reg == lfrr_pkg::CMD_ADD);
    assign busy_flag = (quot_reg > busy_limit_reg) || irq_over_reg;
    assign id_ok     = (int'(id_reg) < lfrr_pkg::CORE_COUNT);
    assign append    = cmd.finish && is_add && !busy_flag && id_ok && (count_reg < eff_limit);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish && (cmd_reg == lfrr_pkg::CMD_CLEAR))
        begin
            count_next = '0;
        end
        else if (append)
        begin
            count_next = count_reg + lfrr_pkg::CNT_W'(1);
        end
    end

    // Result packing, lowest field first.
    assign out_fields = {count_next,
                         is_add ? quot_reg : '0,
                         is_add && busy_flag,
                         chosen_reg,
                         found_reg};

    // Capture of the accepted transaction and the arithmetic sequence.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= lfrr_pkg::cmd_t'(s_tuser);
            id_reg      <= s_tdata[lfrr_pkg::OFF_CORE_ID +: lfrr_pkg::CORE_W];
            system_reg  <= s_tdata[lfrr_pkg::OFF_SYSTEM  +: lfrr_pkg::TIME_W];
            idle_reg    <= s_tdata[lfrr_pkg::OFF_IDLE    +: lfrr_pkg::TIME_W];
            iowait_reg  <= s_tdata[lfrr_pkg::OFF_IOWAIT  +: lfrr_pkg::TIME_W];
            irq_reg     <= s_tdata[lfrr_pkg::OFF_IRQ     +: lfrr_pkg::TIME_W];
            softirq_reg <= s_tdata[lfrr_pkg::OFF_SOFTIRQ +: lfrr_pkg::TIME_W];
            last_reg    <= s_tdata[lfrr_pkg::OFF_LAST    +: lfrr_pkg::CORE_W];
            req_reg     <= s_tdata[lfrr_pkg::OFF_REQ     +: lfrr_pkg::CORE_W];
            mask_reg    <= s_tdata[lfrr_pkg::OFF_MASK    +: lfrr_pkg::MASK_W];
            acc_reg     <= lfrr_pkg::TOTAL_W'(s_tdata[lfrr_pkg::OFF_USER +: lfrr_pkg::TIME_W])
                         + lfrr_pkg::TOTAL_W'(s_tdata[lfrr_pkg::OFF_NICE +: lfrr_pkg::TIME_W]);
            idle_io_reg <= lfrr_pkg::PAIR_W'(s_tdata[lfrr_pkg::OFF_IDLE +: lfrr_pkg::TIME_W])
                         + lfrr_pkg::PAIR_W'(s_tdata[lfrr_pkg::OFF_IOWAIT +: lfrr_pkg::TIME_W]);
            irq_sum_reg <= lfrr_pkg::PAIR_W'(s_tdata[lfrr_pkg::OFF_IRQ +: lfrr_pkg::TIME_W])
                         + lfrr_pkg::PAIR_W'(s_tdata[lfrr_pkg::OFF_SOFTIRQ +: lfrr_pkg::TIME_W]);
            step_reg     <= '0;
            quot_reg     <= '0;
            irq_over_reg <= 1'b0;
            idx_reg      <= '0;
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
            chosen_reg   <= '0;
        end
        if (cmd.sum_step)
        begin
            acc_reg  <= acc_reg + lfrr_pkg::TOTAL_W'(term)
                      + lfrr_pkg::TOTAL_W'(step_reg == '0);
            step_reg <= step_reg + lfrr_pkg::STEP_W'(1);
        end
        if (cmd.busy_step)
        begin
            num_reg      <= lfrr_pkg::NUM_W'(acc_reg - lfrr_pkg::TOTAL_W'(idle_io_reg));
            irq_over_reg <= (irq_sum_reg > irq_limit_reg);
        end
        if (cmd.mul_step)
        begin
            num_reg  <= lfrr_pkg::NUM_W'(num_reg[lfrr_pkg::TOTAL_W-1:0])
                      * lfrr_pkg::NUM_W'(lfrr_pkg::PERCENT_SCALE);
            step_reg <= lfrr_pkg::STEP_W'(lfrr_pkg::DIV_STEPS - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                num_reg <= num_reg - div_shifted;
            end
            quot_reg <= {quot_reg[lfrr_pkg::PCT_W-2:0], div_ge};
            step_reg <= step_reg - lfrr_pkg::STEP_W'(1);
        end
        if (cmd.find_step)
        begin
            idx_reg <= idx_wrap;
        end
        if (cmd.scan_step)
        begin
            if (hit)
            begin
                found_reg  <= 1'b1;
                chosen_reg <= entry;
            end
            else if (in_range)
            begin
                idx_reg      <= idx_wrap;
                scan_cnt_reg <= scan_cnt_reg + lfrr_pkg::CNT_W'(1);
            end
        end
    end

    // List storage is written only at the fill position.
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            list_reg[count_reg[lfrr_pkg::IDX_W-1:0]] <= id_reg;
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= lfrr_pkg::M_TDATA_W'(out_fields);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status toward the controller.
    always_comb
    begin
        status.in_cmd     = lfrr_pkg::cmd_t'(s_tuser);
        status.in_valid   = s_tvalid;
        status.list_empty = (count_reg == '0);
        status.sum_last   = (step_reg == lfrr_pkg::STEP_W'(lfrr_pkg::SUM_STEPS - 1));
        status.div_last   = (step_reg == '0);
        status.find_done  = find_match || (idx_plus == count_reg);
        status.scan_end   = hit || !in_range;
        status.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Result field positions in m_tdata, lowest bit first.
    localparam int RES_FOUND  = 0;
    localparam int RES_CHOSEN = 1;
    localparam int RES_BUSY   = 7;
    localparam int RES_PCT    = 8;
    localparam int RES_COUNT  = 15;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [lfrr_pkg::TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        lfrr_pkg::cmd_t              cmd;
        logic [lfrr_pkg::CORE_W-1:0] core_id;
        logic [lfrr_pkg::TIME_W-1:0] user;
        logic [lfrr_pkg::TIME_W-1:0] nice;
        logic [lfrr_pkg::TIME_W-1:0] sys;
        logic [lfrr_pkg::TIME_W-1:0] idle;
        logic [lfrr_pkg::TIME_W-1:0] iowait;
        logic [lfrr_pkg::TIME_W-1:0] irq;
        logic [lfrr_pkg::TIME_W-1:0] softirq;
        logic [lfrr_pkg::CORE_W-1:0] last_core;
        logic [lfrr_pkg::CORE_W-1:0] requester;
        logic [lfrr_pkg::MASK_W-1:0] full_mask;
    } pick_request_t;

    typedef struct packed {
        logic                        found;
        logic [lfrr_pkg::CORE_W-1:0] chosen;
        logic                        busy;
        logic [lfrr_pkg::PCT_W-1:0]  percent;
        logic [lfrr_pkg::CNT_W-1:0]  count;
    } pick_reply_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [lfrr_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [lfrr_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lfrr_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [lfrr_pkg::CMD_W-1:0]      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lfrr_pkg::M_TDATA_W-1:0]  m_tdata;

    // Shadow copy of the block's registers and idle-core list.
    logic [lfrr_pkg::PCT_W-1:0]      busy_limit_q;
    logic [lfrr_pkg::IRQ_LIM_W-1:0]  irq_limit_q;
    logic [lfrr_pkg::MAXC_W-1:0]     max_cores_q;
    logic [lfrr_pkg::CORE_W-1:0]     idle_cores [lfrr_pkg::LIST_DEPTH];
    int                              idle_len;

    pick_reply_t                     pending_replies [$];
    int                              error_count;
    int                              sent_count;
    int                              stall_left;
    bit                              steady;
    logic [lfrr_pkg::CORE_W-1:0]     last_pick;

    load_filtered_round_robin_picker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // Predicts one result and advances the shadow list.
    function automatic pick_reply_t predict_pick_reply(pick_request_t rq);
        pick_reply_t                 r;
        logic [63:0]                 total;
        logic [63:0]                 busy_time;
        logic [63:0]                 pct;
        logic [32:0]                 irq_sum;
        logic [lfrr_pkg::CORE_W-1:0] c;
        int                          lim;
        int                          start;
        r = '0;
        lim = (int'(max_cores_q) < lfrr_pkg::LIST_DEPTH) ? int'(max_cores_q)
                                                         : lfrr_pkg::LIST_DEPTH;
        unique case (rq.cmd)
            lfrr_pkg::CMD_CLEAR: idle_len = 0;
            lfrr_pkg::CMD_ADD:
            begin
                total = 64'(rq.user) + 64'(rq.nice) + 64'(rq.sys) + 64'(rq.idle)
                      + 64'(rq.iowait) + 64'(rq.irq) + 64'(rq.softirq) + 64'd1;
                busy_time = total - 64'(rq.idle) - 64'(rq.iowait);
                pct = (busy_time * lfrr_pkg::PERCENT_SCALE) / total;
                irq_sum = 33'(rq.irq) + 33'(rq.softirq);
                r.percent = pct[lfrr_pkg::PCT_W-1:0];
                r.busy = (pct > 64'(busy_limit_q)) || (irq_sum > 33'(irq_limit_q));
                if (!r.busy && int'(rq.core_id) < lfrr_pkg::CORE_COUNT && idle_len < lim)
                begin
                    idle_cores[idle_len] = rq.core_id;
                    idle_len++;
                end
            end
            lfrr_pkg::CMD_PICK:
            begin
                if (idle_len > 0 && idle_len <= lfrr_pkg::LIST_DEPTH)
                begin
                    start = 0;
                    for (int i = 0; i < idle_len; i++)
                    begin
                        if (idle_cores[i] == rq.last_core)
                        begin
                            start = (i + 1) % idle_len;
                            break;
                        end
                    end
                    for (int i = 0; i < lim; i++)
                    begin
                        c = idle_cores[(start + i) % idle_len];
                        if (c != rq.requester && !rq.full_mask[c])
                        begin
                            r.found = 1'b1;
                            r.chosen = c;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = lfrr_pkg::CNT_W'(idle_len);
        return r;
    endfunction

    function automatic pick_request_t plain_request(lfrr_pkg::cmd_t cmd);
        pick_request_t rq;
        rq = '0;
        rq.cmd = cmd;
        return rq;
    endfunction

    function automatic pick_request_t add_request(logic [lfrr_pkg::CORE_W-1:0] core,
        logic [lfrr_pkg::TIME_W-1:0] user, logic [lfrr_pkg::TIME_W-1:0] sys,
        logic [lfrr_pkg::TIME_W-1:0] idle, logic [lfrr_pkg::TIME_W-1:0] iowait,
        logic [lfrr_pkg::TIME_W-1:0] irq, logic [lfrr_pkg::TIME_W-1:0] softirq);
        pick_request_t rq;
        rq = plain_request(lfrr_pkg::CMD_ADD);
        rq.core_id = core;
        rq.user = user;
        rq.sys = sys;
        rq.idle = idle;
        rq.iowait = iowait;
        rq.irq = irq;
        rq.softirq = softirq;
        return rq;
    endfunction

    function automatic pick_request_t pick_request(logic [lfrr_pkg::CORE_W-1:0] last,
        logic [lfrr_pkg::CORE_W-1:0] req, logic [lfrr_pkg::MASK_W-1:0] mask);
        pick_request_t rq;
        rq = plain_request(lfrr_pkg::CMD_PICK);
        rq.last_core = last;
        rq.requester = req;
        rq.full_mask = mask;
        return rq;
    endfunction

    // Random item with every field random, command included.
    function automatic pick_request_t noise_request();
        pick_request_t rq;
        rq.cmd = lfrr_pkg::cmd_t'($urandom_range(0, 3));
        rq.core_id = lfrr_pkg::CORE_W'($urandom);
        rq.user = lfrr_pkg::TIME_W'($urandom);
        rq.nice = lfrr_pkg::TIME_W'($urandom);
        rq.sys = lfrr_pkg::TIME_W'($urandom);
        rq.idle = lfrr_pkg::TIME_W'($urandom);
        rq.iowait = lfrr_pkg::TIME_W'($urandom);
        rq.irq = lfrr_pkg::TIME_W'($urandom);
        rq.softirq = lfrr_pkg::TIME_W'($urandom);
        rq.last_core = lfrr_pkg::CORE_W'($urandom);
        rq.requester = lfrr_pkg::CORE_W'($urandom);
        rq.full_mask = {$urandom, $urandom};
        return rq;
    endfunction

    // Add with a load profile: mostly light cores, some near the limit.
    function automatic pick_request_t random_add();
        pick_request_t rq;
        int            mode;
        int unsigned   span;
        int unsigned   share;
        mode = $urandom_range(0, 99);
        rq = noise_request();
        rq.cmd = lfrr_pkg::CMD_ADD;
        if (mode < 10)
        begin
            // Fully random counters.
        end
        else if (mode < 15)
        begin
            rq = add_request(rq.core_id, '0, '0, '0, '0, '0, '0);
        end
        else if (mode < 20)
        begin
            rq = add_request(rq.core_id, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                             TIME_MAX, TIME_MAX);
            rq.nice = TIME_MAX;
        end
        else if (mode < 45)
        begin
            span = $urandom_range(200, 200000);
            share = span * $urandom_range(0, 100) / 100;
            rq = add_request(rq.core_id, lfrr_pkg::TIME_W'(share), '0,
                             lfrr_pkg::TIME_W'(span - share),
                             lfrr_pkg::TIME_W'($urandom_range(0, 50)), '0, '0);
            if ($urandom_range(0, 1) == 1)
                rq.irq = lfrr_pkg::TIME_W'($urandom_range(0, 30));
        end
        else
        begin
            rq.idle = lfrr_pkg::TIME_W'($urandom_range(32'h7FFF_FFFF, 32'h0010_0000));
            rq.iowait = lfrr_pkg::TIME_W'($urandom_range(0, 1000));
            rq.user = lfrr_pkg::TIME_W'($urandom_range(0, rq.idle >> 7));
            rq.nice = lfrr_pkg::TIME_W'($urandom_range(0, rq.idle >> 7));
            rq.sys = lfrr_pkg::TIME_W'($urandom_range(0, rq.idle >> 7));
            rq.irq = ($urandom_range(0, 2) == 0) ? '0
                   : lfrr_pkg::TIME_W'($urandom_range(0, 400000));
            rq.softirq = ($urandom_range(0, 2) == 0) ? '0
                       : lfrr_pkg::TIME_W'($urandom_range(0, 400000));
        end
        return rq;
    endfunction

    // Pick aimed at the current list, with a varied queue-full mask.
    function automatic pick_request_t random_pick();
        pick_request_t               rq;
        logic [lfrr_pkg::CORE_W-1:0] last;
        logic [lfrr_pkg::CORE_W-1:0] req;
        logic [lfrr_pkg::MASK_W-1:0] mask;
        int                          sel;
        sel = $urandom_range(0, 9);
        last = lfrr_pkg::CORE_W'($urandom);
        if (sel < 5 && idle_len > 0)
            last = idle_cores[$urandom_range(0, idle_len - 1)];
        else if (sel < 7)
            last = last_pick;
        req = lfrr_pkg::CORE_W'($urandom);
        if ($urandom_range(0, 2) == 0 && idle_len > 0)
            req = idle_cores[$urandom_range(0, idle_len - 1)];
        sel = $urandom_range(0, 9);
        if (sel < 4)
            mask = '0;
        else if (sel < 7)
            mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        else if (sel < 8)
            mask = '1;
        else
            mask = {$urandom, $urandom};
        rq = pick_request(last, req, mask);
        return rq;
    endfunction

    // Sends one transaction and queues its predicted result on acceptance.
    task automatic send_item(pick_request_t rq);
        int          gap;
        pick_reply_t r;
        gap = (!steady && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = '0;
        s_tdata[lfrr_pkg::OFF_CORE_ID +: lfrr_pkg::CORE_W] = rq.core_id;
        s_tdata[lfrr_pkg::OFF_USER    +: lfrr_pkg::TIME_W] = rq.user;
        s_tdata[lfrr_pkg::OFF_NICE    +: lfrr_pkg::TIME_W] = rq.nice;
        s_tdata[lfrr_pkg::OFF_SYSTEM  +: lfrr_pkg::TIME_W] = rq.sys;
        s_tdata[lfrr_pkg::OFF_IDLE    +: lfrr_pkg::TIME_W] = rq.idle;
        s_tdata[lfrr_pkg::OFF_IOWAIT  +: lfrr_pkg::TIME_W] = rq.iowait;
        s_tdata[lfrr_pkg::OFF_IRQ     +: lfrr_pkg::TIME_W] = rq.irq;
        s_tdata[lfrr_pkg::OFF_SOFTIRQ +: lfrr_pkg::TIME_W] = rq.softirq;
        s_tdata[lfrr_pkg::OFF_LAST    +: lfrr_pkg::CORE_W] = rq.last_core;
        s_tdata[lfrr_pkg::OFF_REQ     +: lfrr_pkg::CORE_W] = rq.requester;
        s_tdata[lfrr_pkg::OFF_MASK    +: lfrr_pkg::MASK_W] = rq.full_mask;
        s_tuser = rq.cmd;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        r = predict_pick_reply(rq);
        if (rq.cmd == lfrr_pkg::CMD_PICK && r.found)
            last_pick = r.chosen;
        if (rq.cmd != lfrr_pkg::CMD_NOP)
            sent_count++;
        pending_replies.push_back(r);
    endtask

    // Waits until every result has arrived and the block has gone quiet.
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [lfrr_pkg::CFG_ADDR_W-1:0] idx,
        logic [lfrr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = value;
        unique case (idx)
            lfrr_pkg::REG_BUSY_LIMIT: busy_limit_q = value[lfrr_pkg::PCT_W-1:0];
            lfrr_pkg::REG_IRQ_LIMIT:  irq_limit_q = value[lfrr_pkg::IRQ_LIM_W-1:0];
            lfrr_pkg::REG_MAX_CORES:  max_cores_q = value[lfrr_pkg::MAXC_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
            error_count++;
        end
    endtask

    // Receiver: random stalls, none started during the steady stretch.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready = 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 4)
        begin
            stall_left = $urandom_range(0, 4);
            m_tready = 1'b0;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    // Compares each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        pick_reply_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                expected = pending_replies.pop_front();
                check_field("found", 32'(expected.found), 32'(m_tdata[RES_FOUND]));
                check_field("chosen_core", 32'(expected.chosen),
                            32'(m_tdata[RES_CHOSEN +: lfrr_pkg::CORE_W]));
                check_field("core_busy", 32'(expected.busy), 32'(m_tdata[RES_BUSY]));
                check_field("busy_percent", 32'(expected.percent),
                            32'(m_tdata[RES_PCT +: lfrr_pkg::PCT_W]));
                check_field("list_count", 32'(expected.count),
                            32'(m_tdata[RES_COUNT +: lfrr_pkg::CNT_W]));
            end
        end
    end

    // Picks and commands on an empty list with the reset settings.
    task automatic test_empty_list();
        send_item(pick_request(6'd0, 6'd1, '0));
        send_item(plain_request(lfrr_pkg::CMD_NOP));
        send_item(plain_request(lfrr_pkg::CMD_CLEAR));
    endtask

    // Busy decisions at the counter extremes and right at both limits.
    task automatic test_load_filter();
        send_item(add_request(6'd1, '0, '0, '0, '0, '0, '0));
        send_item(add_request(6'd2, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                              TIME_MAX, TIME_MAX));
        send_item(add_request(6'd5, '0, '0, TIME_MAX, '0, '0, '0));
        send_item(add_request(6'd63, 31'd100, '0, 31'd5000000, 31'd7, 31'd600000,
                              31'd400000));
        send_item(add_request(6'd7, 31'd100, '0, 31'd5000000, '0, 31'd600001, 31'd400000));
        send_item(add_request(6'd0, 31'd79, '0, 31'd20, '0, '0, '0));
        send_item(add_request(6'd9, 31'd80, '0, 31'd19, '0, '0, '0));
        send_item(add_request(6'd12, 31'd3, 31'd2, 31'd90000, 31'd9, '0, '0));
        send_item(add_request(6'd13, 31'd3, 31'd2, 31'd90000, 31'd9, '0, '0));
    endtask

    // Round-robin walk: absent last core, wrap-around, requester and full queues.
    task automatic test_round_robin();
        send_item(pick_request(6'd40, 6'd50, '0));
        send_item(pick_request(6'd5, 6'd50, '0));
        send_item(pick_request(6'd12, 6'd50, '0));
        send_item(pick_request(6'd5, 6'd63, '0));
        send_item(pick_request(6'd5, 6'd50, 64'h8000_0000_0000_0001));
        send_item(pick_request(6'd5, 6'd50, '1));
    endtask

    // Limit lowered below the list length: only part of the walk is scanned.
    task automatic test_shrunken_limit();
        wait_for_drain();
        write_register(lfrr_pkg::REG_MAX_CORES, 32'd2);
        send_item(pick_request(6'd5, 6'd50, 64'h8000_0000_0000_0001));
        send_item(pick_request(6'd63, 6'd50, '0));
        send_item(add_request(6'd20, '0, '0, 31'd90000, '0, '0, '0));
    endtask

    // Register extremes on both sides of each threshold.
    task automatic test_register_extremes();
        wait_for_drain();
        write_register(lfrr_pkg::REG_BUSY_LIMIT, 32'd0);
        write_register(lfrr_pkg::REG_IRQ_LIMIT, 32'hFFFF_FFFF);
        write_register(lfrr_pkg::REG_MAX_CORES, 32'd16);
        send_item(plain_request(lfrr_pkg::CMD_CLEAR));
        send_item(add_request(6'd3, '0, '0, TIME_MAX, '0, TIME_MAX, TIME_MAX));
        send_item(add_request(6'd4, '0, '0, 31'd1000, '0, '0, '0));
        wait_for_drain();
        write_register(lfrr_pkg::REG_BUSY_LIMIT, 32'd100);
        write_register(lfrr_pkg::REG_IRQ_LIMIT, 32'd0);
        write_register(lfrr_pkg::REG_MAX_CORES, 32'd1);
        send_item(add_request(6'd8, '0, '0, 31'd1000, '0, '0, 31'd1));
        send_item(add_request(6'd8, '0, '0, '0, '0, '0, '0));
    endtask

    // Random sequences: mostly clear, adds and picks, with noise and broken runs.
    task automatic test_random_traffic();
        int round;
        int kind;
        int n;
        int sel;
        round = 0;
        while (sent_count < 1430)
        begin
            if (round % 8 == 7)
            begin
                wait_for_drain();
                sel = $urandom_range(0, 3);
                write_register(lfrr_pkg::REG_BUSY_LIMIT,
                               (sel == 0) ? 32'd0 : (sel == 1) ? 32'd100 :
                               32'($urandom_range(30, 95)));
                sel = $urandom_range(0, 4);
                write_register(lfrr_pkg::REG_IRQ_LIMIT, (sel == 0) ? 32'd0 :
                               (sel == 1) ? 32'hFFFF_FFFF :
                               (sel == 2) ? $urandom : 32'd1000000);
                sel = $urandom_range(0, 3);
                write_register(lfrr_pkg::REG_MAX_CORES,
                               (sel == 0) ? 32'd1 : (sel == 1) ? 32'd16 :
                               32'($urandom_range(1, 16)));
            end
            steady = (sent_count >= 500 && sent_count < 800);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                send_item(plain_request(lfrr_pkg::CMD_CLEAR));
                n = $urandom_range(1, 20);
                repeat (n) send_item(random_add());
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                        send_item(random_add());
                    else
                        send_item(random_pick());
                end
            end
            else if (kind == 7)
            begin
                n = $urandom_range(3, 10);
                repeat (n) send_item(noise_request());
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(random_pick());
                n = $urandom_range(1, 6);
                repeat (n) send_item(random_add());
            end
            else
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_item(random_add());
                send_item(plain_request(lfrr_pkg::CMD_CLEAR));
                n = $urandom_range(1, 3);
                repeat (n) send_item(random_pick());
            end
            round++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        busy_limit_q = lfrr_pkg::PCT_W'(80);
        irq_limit_q = lfrr_pkg::IRQ_LIM_W'(1000000);
        max_cores_q = lfrr_pkg::MAXC_W'(4);
        idle_len = 0;
        error_count = 0;
        sent_count = 0;
        stall_left = 0;
        steady = 1'b0;
        last_pick = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_load_filter();
        test_round_robin();
        test_shrunken_limit();
        test_register_extremes();
        test_random_traffic();

        wait_for_drain();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== load_filtered_round_robin_picker.f =====
rtl/lfrr_pkg.sv
rtl/lfrr_ctrl.sv
rtl/lfrr_dpath.sv
rtl/load_filtered_round_robin_picker.sv
bench/testbench.sv
